>>> rtl/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

    // Field widths.
    localparam int VALUE_W = 31;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // Long division works on a 32-bit word, eight quotient bits per cycle.
    localparam int DIV_W       = 32;
    localparam int CHUNK_W     = 8;
    localparam int N_CHUNKS    = DIV_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(N_CHUNKS);

    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 16;

    localparam int ASCII_ZERO        = 48;
    localparam int ASCII_LETTER_BASE = 55;
    localparam int DECIMAL_LIMIT     = 10;

    localparam int MAX_DIGITS_DEF = 31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic pop;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic chunk_last;
        logic quot_zero;
        logic count_full;
        logic count_one;
        logic out_free;
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(DECIMAL_LIMIT)) begin
            c = CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
        end else begin
            c = CHAR_W'(ASCII_LETTER_BASE) + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

>>> rtl/rdc_if.sv
`timescale 1ns / 1ps

interface rdc_in_if;
    logic                         valid;
    logic                         ready;
    logic [rdc_pkg::VALUE_W-1:0]  value;
    logic [rdc_pkg::RADIX_W-1:0]  radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> rtl/rdc_ctrl.sv
`timescale 1ns / 1ps

module rdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rdc_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output rdc_pkg::t_cmd  o_cmd
);

    rdc_pkg::t_state r_state;
    rdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rdc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rdc_pkg::S_DIV;
                end
            end
            rdc_pkg::S_DIV: begin
                if (i_stat.chunk_last) begin
                    n_state = rdc_pkg::S_PUSH;
                end
            end
            rdc_pkg::S_PUSH: begin
                if (i_stat.quot_zero || i_stat.count_full) begin
                    n_state = rdc_pkg::S_EMIT;
                end else begin
                    n_state = rdc_pkg::S_DIV;
                end
            end
            rdc_pkg::S_EMIT: begin
                if (i_stat.out_free && i_stat.count_one) begin
                    n_state = rdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            rdc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rdc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rdc_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
            end
            rdc_pkg::S_EMIT: begin
                o_cmd.pop = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rdc_dpath.sv
`timescale 1ns / 1ps

module rdc_dpath #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdc_pkg::t_cmd               i_cmd,
    input  logic [rdc_pkg::VALUE_W-1:0] i_value,
    input  logic [rdc_pkg::RADIX_W-1:0] i_radix,
    input  logic                        i_out_ready,
    output rdc_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    output logic [rdc_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                        o_last_digit
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int DV_W  = rdc_pkg::DIV_W;
    localparam int RD_W  = rdc_pkg::RADIX_W;
    localparam int DG_W  = rdc_pkg::DIGIT_W;

    logic [DV_W-1:0]                 r_dvd;
    logic [DV_W-1:0]                 n_dvd;
    logic [RD_W-1:0]                 r_radix;
    logic [RD_W-1:0]                 n_radix;
    logic [RD_W-1:0]                 r_rem;
    logic [RD_W-1:0]                 n_rem;
    logic [rdc_pkg::CHUNK_CNT_W-1:0] r_chunk;
    logic [rdc_pkg::CHUNK_CNT_W-1:0] n_chunk;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic [DG_W-1:0]                 r_stack [MAX_DIGITS];
    logic [DG_W-1:0]                 n_stack [MAX_DIGITS];
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [rdc_pkg::CHAR_W-1:0]      r_out_char;
    logic [rdc_pkg::CHAR_W-1:0]      n_out_char;
    logic                            r_out_last;
    logic                            n_out_last;

    logic [DV_W-1:0] step_dvd;
    logic [RD_W-1:0] step_rem;
    logic [RD_W-1:0] sat_radix;

    // Eight steps of restoring division; quotient bits shift in at the bottom.
    always_comb begin
        step_dvd = r_dvd;
        step_rem = r_rem;
        for (int i = 0; i < rdc_pkg::CHUNK_W; i++) begin
            step_rem = {step_rem[RD_W-2:0], step_dvd[DV_W-1]};
            step_dvd = {step_dvd[DV_W-2:0], 1'b0};
            if (step_rem >= r_radix) begin
                step_rem    = step_rem - r_radix;
                step_dvd[0] = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_radix < RD_W'(rdc_pkg::RADIX_MIN)) begin
            sat_radix = RD_W'(rdc_pkg::RADIX_MIN);
        end else if (i_radix > RD_W'(rdc_pkg::RADIX_MAX)) begin
            sat_radix = RD_W'(rdc_pkg::RADIX_MAX);
        end else begin
            sat_radix = i_radix;
        end
    end

    always_comb begin
        n_dvd       = r_dvd;
        n_radix     = r_radix;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_count     = r_count;
        n_stack     = r_stack;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_dvd   = DV_W'(i_value);
            n_radix = sat_radix;
            n_rem   = '0;
            n_chunk = '0;
            n_count = '0;
        end

        if (i_cmd.div_step) begin
            n_dvd   = step_dvd;
            n_rem   = step_rem;
            n_chunk = r_chunk + 1'b1;
        end

        // The newest digit sits on top of the stack at index zero.
        if (i_cmd.push) begin
            for (int i = MAX_DIGITS - 1; i > 0; i--) begin
                n_stack[i] = r_stack[i-1];
            end
            n_stack[0] = r_rem[DG_W-1:0];
            n_count    = r_count + 1'b1;
            n_rem      = '0;
            n_chunk    = '0;
        end

        if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                n_stack[i] = r_stack[i+1];
            end
            n_stack[MAX_DIGITS-1] = '0;
            n_count     = r_count - 1'b1;
            n_out_valid = 1'b1;
            n_out_char  = rdc_pkg::digit_to_ascii(r_stack[0]);
            n_out_last  = (r_count == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_radix    <= n_radix;
        r_rem      <= n_rem;
        r_stack    <= n_stack;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        o_stat.chunk_last = (r_chunk == rdc_pkg::CHUNK_CNT_W'(rdc_pkg::N_CHUNKS - 1));
        o_stat.quot_zero  = (r_dvd == '0);
        o_stat.count_full = (r_count == CNT_W'(MAX_DIGITS - 1));
        o_stat.count_one  = (r_count == CNT_W'(1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

>>> rtl/radix_digit_converter.sv
`timescale 1ns / 1ps

// Converts a non-negative 31-bit integer to its ASCII digit string in a radix
// from two to sixteen, one digit per output request, most significant digit
// first, with last_digit set on the final digit. A radix below two is taken as
// two and one above sixteen as sixteen; zero gives the single digit '0'. If the
// value needs more than MAX_DIGITS digits, only the MAX_DIGITS least
// significant ones are sent. One request is converted at a time. Each digit
// passes through the shared long divider in chunks of eight quotient bits,
// then its remainder is pushed onto the digit stack, and the digits then
// leave one by one through the output register. A new request is taken as
// soon as the last digit sits in the output register.

module radix_digit_converter #(
    parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdc_in_if.sink     i_in,
    rdc_out_if.source  o_out
);

    rdc_pkg::t_cmd  w_cmd;
    rdc_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_out_valid;
    logic [rdc_pkg::CHAR_W-1:0] w_digit_char;
    logic           w_last_digit;

    // The controller sequences divide, push and emit phases.
    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the divider, the digit stack and the output register.
    rdc_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_in.value),
        .i_radix      (i_in.radix),
        .i_out_ready  (o_out.ready),
        .o_stat       (w_stat),
        .o_out_valid  (w_out_valid),
        .o_digit_char (w_digit_char),
        .o_last_digit (w_last_digit)
    );

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.digit_char = w_digit_char;
    assign o_out.last_digit = w_last_digit;

endmodule

>>> rtl/rdc_checker.sv
`timescale 1ns / 1ps

module rdc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [rdc_pkg::CHAR_W-1:0] i_digit_char,
    input logic                       i_last_digit
);

    // A request just taken keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted request");

    // While a digit other than the last is shown, the request is unfinished.
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last_digit) |-> !i_in_ready)
        else $error("input ready while digits of a request remain");

    // Every digit is '0' to '9' or 'A' to 'F'.
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_digit_char >= 7'd48 && i_digit_char <= 7'd57) ||
                         (i_digit_char >= 7'd65 && i_digit_char <= 7'd70)))
        else $error("digit character out of range");

    // A stalled digit holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_digit_char) && $stable(i_last_digit)))
        else $error("stalled digit changed");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_digit_char (o_out.digit_char),
    .i_last_digit (o_out.last_digit)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

// The block takes a non-negative value and a radix from its input channel and
// returns the digits of that value on the output channel, one request per
// digit, most significant first, with last_digit set on the final digit.
// A scoreboard predicts the digit string of every accepted input request,
// and each output request is checked against the oldest digit that is still
// expected.
module testbench;

    localparam int     VALUE_W        = rdc_pkg::VALUE_W;
    localparam int     RADIX_W        = rdc_pkg::RADIX_W;
    localparam int     CHAR_W         = rdc_pkg::CHAR_W;
    localparam int     CLK_PERIOD     = 12;
    localparam int     RESET_CYCLES   = 6;
    localparam int     N_RANDOM       = 310;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 200;
    localparam longint TIMEOUT_CYCLES = 2_500_000;

    // The scoreboard keeps the expected digits of all accepted requests in
    // order. The block converts one request at a time, so the digits of all
    // requests leave in the order the requests were taken.
    class digit_scoreboard;
        typedef struct {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_digit;

        t_digit pending_digits[$];
        int     max_digits = rdc_pkg::MAX_DIGITS_DEF;
        int     requests;
        int     clamped_radix;
        int     digits_checked;
        int     mismatches;

        // Expands one accepted request into its expected digits.
        function void note_request(logic [VALUE_W-1:0] value,
                                   logic [RADIX_W-1:0] radix);
            int unsigned       base;
            bit [31:0]         rest;
            logic [CHAR_W-1:0] lsd_first[$];
            int unsigned       d;
            t_digit            item;

            requests++;
            base = radix;
            if (base < rdc_pkg::RADIX_MIN) begin
                base = rdc_pkg::RADIX_MIN;
                clamped_radix++;
            end else if (base > rdc_pkg::RADIX_MAX) begin
                base = rdc_pkg::RADIX_MAX;
                clamped_radix++;
            end

            // Remainders come out least significant first. Zero still gives one
            // digit, and digits beyond the buffer depth are dropped at the top.
            rest = value;
            do begin
                d = rest % base;
                if (d < rdc_pkg::DECIMAL_LIMIT) begin
                    lsd_first.push_back(CHAR_W'(rdc_pkg::ASCII_ZERO + d));
                end else begin
                    lsd_first.push_back(CHAR_W'(rdc_pkg::ASCII_LETTER_BASE + d));
                end
                rest = rest / base;
            end while (rest != 0 && lsd_first.size() < max_digits);

            for (int k = lsd_first.size() - 1; k >= 0; k--) begin
                item.ch   = lsd_first[k];
                item.last = (k == 0);
                pending_digits.push_back(item);
            end
        endfunction

        function void check_digit(logic [CHAR_W-1:0] ch, logic last);
            t_digit want;

            digits_checked++;
            if (pending_digits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected digit 0x%02h last=%b with nothing pending",
                             $time, ch, last);
                end
                return;
            end
            want = pending_digits.pop_front();
            if (ch !== want.ch || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: digit mismatch: expected 0x%02h last=%b, got 0x%02h last=%b",
                             $time, want.ch, want.last, ch, last);
                end
            end
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rdc_in_if  in_if ();
    rdc_out_if out_if ();

    radix_digit_converter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    digit_scoreboard sb = new();

    // Shared knobs: idle_on switches random gaps on both channels, and
    // hold_requested asks the output side for one long stall while the input
    // side keeps offering requests, so the block fills up and stalls its input.
    bit idle_on        = 1'b1;
    bit hold_requested = 1'b0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!idle_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offers one request after a random gap and returns at the edge where it
    // is taken. Valid stays high when the next request follows without a gap.
    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        in_if.radix <= radix;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(value, radix);
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Output side: checks every digit taken and drives ready with random
    // stalls. The long hold is counted out here, cycle by cycle.
    initial begin
        int  stall_left;
        int  gap;
        bit  hold_done;

        stall_left = 0;
        hold_done  = 1'b0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                sb.check_digit(out_if.digit_char, out_if.last_digit);
            end
            if (hold_requested && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_if.ready <= 1'b0;
                    stall_left = gap - 1;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Input side and overall sequence.
    initial begin
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int                 roll;
        int                 base;
        int                 k;
        longint unsigned    power;

        in_if.valid <= 1'b0;
        in_if.value <= '0;
        in_if.radix <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: zero in several bases, radix codes that saturate
        // low and high, the largest value in the smallest and largest bases,
        // the digit boundaries around nine and ten, and alternating bit patterns.
        send_request(31'd0, 5'd2);
        send_request(31'd0, 5'd10);
        send_request(31'd0, 5'd16);
        send_request(31'd0, 5'd0);
        send_request(31'd1, 5'd1);
        send_request(31'h7FFF_FFFF, 5'd2);
        send_request(31'h7FFF_FFFF, 5'd3);
        send_request(31'h7FFF_FFFF, 5'd10);
        send_request(31'h7FFF_FFFF, 5'd16);
        send_request(31'h7FFF_FFFF, 5'd31);
        send_request(31'd255, 5'd17);
        send_request(31'd9, 5'd10);
        send_request(31'd10, 5'd16);
        send_request(31'd15, 5'd16);
        send_request(31'd16, 5'd16);
        send_request(31'd35, 5'd12);
        send_request(31'd1, 5'd2);
        send_request(31'd2, 5'd2);
        send_request(31'h5555_5555, 5'd2);
        send_request(31'h2AAA_AAAA, 5'd2);
        send_request(31'h4000_0000, 5'd2);
        send_request(31'd123456789, 5'd7);
        send_request(31'd59048, 5'd3);
        send_request(31'd59049, 5'd3);

        // Let the directed part finish before the random part starts.
        wait_for_drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            // Idling is chosen per block of requests, so some stretches run
            // back to back on both sides.
            if (i % 30 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == 100) begin
                hold_requested = 1'b1;
            end
            if (i == 170) begin
                wait_for_drain();
            end

            if ($urandom_range(0, 9) == 0) begin
                radix = RADIX_W'($urandom_range(0, 31));
            end else begin
                radix = RADIX_W'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
            end
            base = (radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
                   (radix > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX : int'(radix);

            // Values of all lengths, small ones, and powers of the radix and
            // one below them, where the digit count changes.
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                value = VALUE_W'($urandom);
            end else if (roll < 60) begin
                value = VALUE_W'($urandom >> $urandom_range(1, 31));
            end else if (roll < 78) begin
                value = VALUE_W'($urandom_range(0, 300));
            end else if (roll < 96) begin
                power = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (power * base <= 64'h7FFF_FFFF) begin
                        power = power * base;
                    end
                end
                value = VALUE_W'(power - $urandom_range(0, 1));
            end else begin
                value = '1;
            end

            send_request(value, radix);
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d requests into %0d digits, %0d of them with a radix code",
                 sb.requests, sb.digits_checked, sb.clamped_radix);
        $display("outside two to sixteen; %0d digit mismatches found.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("radix_digit_converter verification clean");
        end else begin
            $display("radix_digit_converter verification failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("radix_digit_converter verification failed");
        $finish;
    end

endmodule
